### src/banked_memory_mapper_with_rom_trap_macros.svh
// Assertion macros for the banked memory mapper checker.
// Expects clk and arst_n in the scope of each use.
`ifndef BANKED_MEMORY_MAPPER_WITH_ROM_TRAP_MACROS_SVH
`define BANKED_MEMORY_MAPPER_WITH_ROM_TRAP_MACROS_SVH

// same-cycle implication
`define BMM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmm check failed");

// next-cycle implication
`define BMM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmm check failed");

`endif

### src/bmm_pkg.sv
// Shared types and constants for the banked memory mapper.
// No dependencies; used by the interfaces, the decode logic, the top level and the checker.
`default_nettype none
package bmm_pkg;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int BANK_W   = 3;
	localparam int OFFS_W   = 14;
	localparam int ROM_W    = 2;
	localparam int CMD_W    = 3;
	localparam int KIND_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PORT_WR  = 3'd0,
		CMD_MEM_RD   = 3'd1,
		CMD_MEM_WR   = 3'd2,
		CMD_FETCH    = 3'd3,
		CMD_TRAP_CHK = 3'd4
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ROM     = 2'd0,
		KIND_RAM     = 2'd1,
		KIND_DISCARD = 2'd2,
		KIND_TRAP    = 2'd3
	} kind_t;

	localparam logic [ROM_W-1:0] ROM_128  = 2'd0;
	localparam logic [ROM_W-1:0] ROM_48   = 2'd1;
	localparam logic [ROM_W-1:0] ROM_DISK = 2'd2;

	localparam logic [ADDR_W-1:0] PORT_DECODE_MASK = 16'h8002;
	localparam logic [7:0]        TRAP_PAGE_HIGH   = 8'h3D;
	localparam int                LATCH_ROM48_BIT  = 4;
	localparam int                LATCH_LOCK_BIT   = 5;
	localparam logic [BANK_W-1:0] WIN1_RAM_PAGE    = 3'd5;
	localparam logic [BANK_W-1:0] WIN2_RAM_PAGE    = 3'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t             target_kind;
		logic [BANK_W-1:0] bank;
		logic [OFFS_W-1:0] page_offset;
		logic              write_ignored;
		logic              mapping_switched;
	} result_t;

	typedef struct packed {
		logic [DATA_W-1:0] paging_latch;
		logic [ROM_W-1:0]  rom_select;
	} map_state_t;

endpackage
`default_nettype wire

### src/bmm_if.sv
// Handshake channel interfaces: command items, result items, configuration writes.
// Depends on bmm_pkg for field widths.
`default_nettype none
interface bmm_in_if;
	import bmm_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] data_byte;
	modport source (output valid, command, address, data_byte, input ready);
	modport sink (input valid, command, address, data_byte, output ready);
endinterface

interface bmm_out_if;
	import bmm_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] target_kind;
	logic [BANK_W-1:0] bank;
	logic [OFFS_W-1:0] page_offset;
	logic              write_ignored;
	logic              mapping_switched;
	modport source (output valid, target_kind, bank, page_offset, write_ignored,
		mapping_switched, input ready);
	modport sink (input valid, target_kind, bank, page_offset, write_ignored,
		mapping_switched, output ready);
endinterface

interface bmm_cfg_if;
	import bmm_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROM_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### src/bmm_decode.sv
// Address translation, trap detection and paging-port decode for one item.
// Depends on bmm_pkg. Purely combinational.
`default_nettype none
module bmm_decode (
	input  bmm_pkg::item_t      item,
	input  bmm_pkg::map_state_t cur,
	output bmm_pkg::result_t    res,
	output bmm_pkg::map_state_t nxt
);
	import bmm_pkg::*;

	logic [1:0]        window;
	kind_t             xl_kind;
	logic [BANK_W-1:0] xl_bank;
	logic [BANK_W-1:0] rom_bank;
	logic              in_trap_page;
	logic              above_rom;
	logic              enter_disk;
	logic              leave_disk;

	assign window       = item.address[ADDR_W-1 -: 2];
	assign rom_bank     = {1'b0, cur.rom_select};
	assign in_trap_page = (item.address[ADDR_W-1 -: 8] == TRAP_PAGE_HIGH);
	assign above_rom    = (window != 2'd0);
	assign enter_disk   = (cur.rom_select == ROM_48) && in_trap_page;
	assign leave_disk   = (cur.rom_select == ROM_DISK) && above_rom;

	always_comb begin
		unique case (window)
			2'd0: begin
				xl_kind = KIND_ROM;
				xl_bank = rom_bank;
			end
			2'd1: begin
				xl_kind = KIND_RAM;
				xl_bank = WIN1_RAM_PAGE;
			end
			2'd2: begin
				xl_kind = KIND_RAM;
				xl_bank = WIN2_RAM_PAGE;
			end
			default: begin
				xl_kind = KIND_RAM;
				xl_bank = cur.paging_latch[BANK_W-1:0];
			end
		endcase
	end

	always_comb begin
		res = '0;
		nxt = cur;
		unique case (item.command)
			CMD_PORT_WR: begin
				if ((item.address & PORT_DECODE_MASK) == '0) begin
					if (cur.paging_latch[LATCH_LOCK_BIT]) begin
						res.write_ignored = 1'b1;
					end else begin
						nxt.paging_latch = item.data_byte;
						nxt.rom_select   = item.data_byte[LATCH_ROM48_BIT] ? ROM_48 : ROM_128;
					end
				end
			end
			CMD_MEM_RD: begin
				res.target_kind = xl_kind;
				res.bank        = xl_bank;
				res.page_offset = item.address[OFFS_W-1:0];
			end
			CMD_MEM_WR: begin
				res.target_kind = (xl_kind == KIND_ROM) ? KIND_DISCARD : xl_kind;
				res.bank        = xl_bank;
				res.page_offset = item.address[OFFS_W-1:0];
			end
			CMD_FETCH: begin
				res.target_kind = (enter_disk || leave_disk) ? KIND_TRAP : xl_kind;
				res.bank        = (enter_disk || leave_disk) ? rom_bank : xl_bank;
				res.page_offset = item.address[OFFS_W-1:0];
			end
			CMD_TRAP_CHK: begin
				if (enter_disk) begin
					nxt.rom_select       = ROM_DISK;
					res.mapping_switched = 1'b1;
				end else if (leave_disk) begin
					nxt.rom_select       = ROM_48;
					res.mapping_switched = 1'b1;
				end
			end
			default: begin
				// unused commands: all-zero result, no state change
			end
		endcase
	end

endmodule
`default_nettype wire

### src/banked_memory_mapper_with_rom_trap.sv
// Top level of the banked memory mapper: mapping state, result register, handshakes.
// Depends on bmm_pkg, the channel interfaces in bmm_if.sv and bmm_decode.
//
//  channel  | dir | payload                                          | accepted when
//  ---------+-----+--------------------------------------------------+--------------------
//  in_ch    | in  | command, address, data_byte                      | valid && ready
//  out_ch   | out | target_kind, bank, page_offset, write_ignored,   | valid && ready
//           |     | mapping_switched                                 |
//  cfg_ch   | in  | data (boot ROM bank)                             | valid && ready
//
// One item per cycle while the result side keeps ready high; the result is valid in the cycle after acceptance.
// The decode sits between the input ports and the result register; the paging
// latch and ROM select update at the same edge, so the next item sees them.
// in_ch.ready drops only while a result sits unclaimed in the output register.
// Reset clears the latch and selects the 128 ROM; a cfg write reloads the mapping
// the same way with the written boot bank (code 3 maps to the 128 ROM).
`default_nettype none
module banked_memory_mapper_with_rom_trap (
	input  wire      clk,
	input  wire      arst_n,
	bmm_in_if.sink   in_ch,
	bmm_out_if.source out_ch,
	bmm_cfg_if.sink  cfg_ch
);
	import bmm_pkg::*;

	map_state_t state_q;
	map_state_t state_nxt;
	item_t      item;
	result_t    res;
	result_t    out_q;
	logic       out_valid_q;
	logic       in_accept;
	logic       cfg_accept;

	// input can be taken whenever the result register is empty or draining
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_accept   = in_ch.valid && in_ch.ready;
	// configuration is always taken
	assign cfg_ch.ready = 1'b1;
	assign cfg_accept   = cfg_ch.valid;

	assign item.command   = in_ch.command;
	assign item.address   = in_ch.address;
	assign item.data_byte = in_ch.data_byte;

	bmm_decode u_decode (
		.item (item),
		.cur  (state_q),
		.res  (res),
		.nxt  (state_nxt)
	);

	// mapping state; a config write wins over an item (never both by contract)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.paging_latch <= '0;
			state_q.rom_select   <= ROM_128;
		end else if (cfg_accept) begin
			state_q.paging_latch <= '0;
			state_q.rom_select   <= (cfg_ch.data == ROM_128 || cfg_ch.data == ROM_48 ||
				cfg_ch.data == ROM_DISK) ? cfg_ch.data : ROM_128;
		end else if (in_accept) begin
			state_q <= state_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_q <= res;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.target_kind      = out_q.target_kind;
	assign out_ch.bank             = out_q.bank;
	assign out_ch.page_offset      = out_q.page_offset;
	assign out_ch.write_ignored    = out_q.write_ignored;
	assign out_ch.mapping_switched = out_q.mapping_switched;

endmodule
`default_nettype wire

### src/bmm_checker.sv
// Port-level checks for the banked memory mapper, bound to the top level.
// Depends on bmm_pkg and banked_memory_mapper_with_rom_trap_macros.svh.
`default_nettype none
`include "banked_memory_mapper_with_rom_trap_macros.svh"
module bmm_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [bmm_pkg::KIND_W-1:0]  out_target_kind,
	input wire [bmm_pkg::BANK_W-1:0]  out_bank,
	input wire [bmm_pkg::OFFS_W-1:0]  out_page_offset,
	input wire                        out_write_ignored,
	input wire                        out_mapping_switched
);
	import bmm_pkg::*;

	logic port_or_trap_shape;

	assign port_or_trap_shape = (out_target_kind == KIND_ROM) && (out_bank == '0) &&
		(out_page_offset == '0);

	// a pending result is never dropped
	`BMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// every accepted item produces a result next cycle
	`BMM_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid)
	// refused port write carries no translation and no switch
	`BMM_ASSERT_NOW(a_refused_shape, out_valid && out_write_ignored,
		port_or_trap_shape && !out_mapping_switched)
	// a mapping switch carries no translation
	`BMM_ASSERT_NOW(a_switch_shape, out_valid && out_mapping_switched, port_or_trap_shape)

endmodule

bind banked_memory_mapper_with_rom_trap bmm_checker u_bmm_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (in_ch.valid),
	.in_ready             (in_ch.ready),
	.out_valid            (out_ch.valid),
	.out_ready            (out_ch.ready),
	.out_target_kind      (out_ch.target_kind),
	.out_bank             (out_ch.bank),
	.out_page_offset      (out_ch.page_offset),
	.out_write_ignored    (out_ch.write_ignored),
	.out_mapping_switched (out_ch.mapping_switched)
);
`default_nettype wire

### dv/banked_memory_mapper_with_rom_trap_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the banked memory mapper with ROM trap.
// Depends on bmm_pkg, the channel interfaces in bmm_if.sv and the mapper top level.
module banked_memory_mapper_with_rom_trap_test;
	import bmm_pkg::*;

	// command codes 5..7 carry no operation; the block must answer with an all-zero item
	localparam logic [CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;
	// boot code 3 is not a ROM bank; the mapping falls back to the 128 ROM
	localparam logic [ROM_W-1:0]  ROM_UNUSED    = 2'd3;
	// in disk-ROM mode a fetch at or above this PC traps, and a trap check there leaves disk-ROM mode
	localparam logic [ADDR_W-1:0] DISK_EXIT_PC  = 16'h4000;
	localparam int                MAX_SHOWN     = 10;

	logic clk;
	logic arst_n;

	bmm_in_if  in_ch();
	bmm_out_if out_ch();
	bmm_cfg_if cfg_ch();

	banked_memory_mapper_with_rom_trap dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Mapping state as the block should hold it after every accepted item.
	logic [DATA_W-1:0] latch;
	logic [ROM_W-1:0]  rom_sel;

	// Translations still owed by the block, oldest first.
	result_t     pending_results[$];
	int unsigned items_sent;
	int unsigned error_count;
	// when set, neither side inserts gaps
	bit          steady;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Generous cap: several times what a run with the longest stalls on every item needs.
	initial begin : run_limit
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Gap length for either side: mostly none, sometimes short, rarely a long stall; none when steady.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Predict one item and advance the mapping state; one result per item always.
	function automatic result_t map_item(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		result_t r;
		logic    in_trap_page;
		logic    past_disk;
		r = '0;
		in_trap_page = (rom_sel == ROM_48) && (addr[15:8] == TRAP_PAGE_HIGH);
		past_disk    = (rom_sel == ROM_DISK) && (addr >= DISK_EXIT_PC);
		case (cmd)
		CMD_PORT_WR: begin
			// decoded only with address bits 15 and 1 both low
			if ((addr & PORT_DECODE_MASK) == '0) begin
				if (latch[LATCH_LOCK_BIT]) begin
					r.write_ignored = 1'b1;
				end else begin
					latch   = data;
					rom_sel = data[LATCH_ROM48_BIT] ? ROM_48 : ROM_128;
				end
			end
		end
		CMD_MEM_RD, CMD_MEM_WR, CMD_FETCH: begin
			r.page_offset = addr[OFFS_W-1:0];
			case (addr[15:14])
			2'd0: begin
				r.target_kind = KIND_ROM;
				r.bank        = {1'b0, rom_sel};
			end
			2'd1: begin
				r.target_kind = KIND_RAM;
				r.bank        = WIN1_RAM_PAGE;
			end
			2'd2: begin
				r.target_kind = KIND_RAM;
				r.bank        = WIN2_RAM_PAGE;
			end
			default: begin
				r.target_kind = KIND_RAM;
				r.bank        = latch[BANK_W-1:0];
			end
			endcase
			// stores into the ROM window are dropped
			if (cmd == CMD_MEM_WR && addr[15:14] == 2'd0)
				r.target_kind = KIND_DISCARD;
			if (cmd == CMD_FETCH && (in_trap_page || past_disk)) begin
				r.target_kind = KIND_TRAP;
				r.bank        = {1'b0, rom_sel};
			end
		end
		CMD_TRAP_CHK: begin
			if (in_trap_page) begin
				rom_sel            = ROM_DISK;
				r.mapping_switched = 1'b1;
			end else if (past_disk) begin
				rom_sel            = ROM_48;
				r.mapping_switched = 1'b1;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// Offer one item, hold it until taken, then log its translation.
	// valid stays high on return so back-to-back items need no second assignment.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.command   <= cmd;
		in_ch.address   <= addr;
		in_ch.data_byte <= data;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_results.push_back(map_item(cmd, addr, data));
		items_sent++;
	endtask

	// Stop offering and wait until every owed item has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// then wait on so that the block is left fully idle
		repeat (2) @(posedge clk);
	endtask

	// boot_rom writes take effect at once: latch cleared, ROM reloaded.
	task automatic write_boot_rom(input logic [ROM_W-1:0] value);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		latch   = '0;
		rom_sel = (value == ROM_UNUSED) ? ROM_128 : value;
	endtask

	// Port address that does or does not hit the paging decode.
	function automatic logic [ADDR_W-1:0] port_address(input bit decoded);
		logic [ADDR_W-1:0] a;
		a = 16'($urandom_range(0, 16'hFFFF));
		if (decoded)
			return a & ~PORT_DECODE_MASK;
		case ($urandom_range(0, 2))
		0: a[15] = 1'b1;
		1: a[1] = 1'b1;
		default: a = a | PORT_DECODE_MASK;
		endcase
		return a;
	endfunction

	// Memory addresses weighted toward the trap page and the window borders.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return {TRAP_PAGE_HIGH, 8'($urandom_range(0, 255))};
		if (r < 38) begin
			case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'h3CFF;
			2: return 16'h3E00;
			3: return 16'h3FFF;
			4: return 16'h4000;
			5: return 16'h7FFF;
			6: return 16'h8000;
			7: return 16'hBFFF;
			8: return 16'hC000;
			default: return 16'hFFFF;
			endcase
		end
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic send_random_item();
		int unsigned       pick;
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] data;
		pick = $urandom_range(0, 99);
		data = 8'($urandom_range(0, 255));
		if (pick < 12) begin
			// the lock bit is rare, else the latch freezes for the rest of the phase
			data[LATCH_LOCK_BIT] = ($urandom_range(0, 99) < 4);
			send_item(CMD_PORT_WR, port_address($urandom_range(0, 99) < 75), data);
		end else if (pick < 97) begin
			case ($urandom_range(0, 3))
			0: cmd = CMD_MEM_RD;
			1: cmd = CMD_MEM_WR;
			2: cmd = CMD_FETCH;
			default: cmd = CMD_TRAP_CHK;
			endcase
			send_item(cmd, pick_address(), data);
		end else begin
			send_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
				16'($urandom_range(0, 16'hFFFF)), data);
		end
	endtask

	// Fixed windows and the ROM window in the reset state (128 ROM, page 0 at 0xC000).
	task automatic test_window_map();
		send_item(CMD_MEM_RD, 16'h0000, 8'h00);
		send_item(CMD_MEM_RD, 16'hFFFF, 8'hFF);
		send_item(CMD_MEM_WR, 16'h3FFF, 8'hA5);
		send_item(CMD_MEM_WR, 16'h4000, 8'h5A);
		send_item(CMD_MEM_RD, 16'h8000, 8'h00);
		// trap page means nothing with the 128 ROM in
		send_item(CMD_TRAP_CHK, 16'h3D00, 8'h00);
	endtask

	// Enter the disk ROM from the 48 ROM trap page and leave it above 0x3FFF.
	task automatic test_trap_flow();
		send_item(CMD_PORT_WR, 16'h7FFD, 8'h17);
		send_item(CMD_MEM_RD, 16'hC123, 8'h00);
		send_item(CMD_FETCH, 16'h3DFF, 8'h00);
		send_item(CMD_TRAP_CHK, 16'h3D42, 8'h00);
		send_item(CMD_FETCH, 16'h3FFF, 8'h00);
		send_item(CMD_FETCH, 16'h4000, 8'h00);
		send_item(CMD_TRAP_CHK, 16'h3FFF, 8'h00);
		send_item(CMD_TRAP_CHK, 16'h4000, 8'h00);
		send_item(CMD_FETCH, 16'h3CFF, 8'h00);
	endtask

	// Port decode, the lock bit, and the unused command codes.
	task automatic test_paging_port();
		send_item(CMD_PORT_WR, 16'h8000, 8'hFF);
		send_item(CMD_PORT_WR, 16'h0002, 8'hFF);
		send_item(CMD_MEM_RD, 16'hFFFF, 8'h00);
		send_item(CMD_PORT_WR, 16'h0000, 8'h20);
		send_item(CMD_MEM_RD, 16'hC000, 8'h00);
		send_item(CMD_PORT_WR, 16'h7FFD, 8'hFF);
		send_item(CMD_MEM_RD, 16'h0000, 8'h00);
		for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
			send_item(3'(c), 16'hFFFF, 8'hFF);
	endtask

	// Every boot code, including the one that is not a bank.
	task automatic test_boot_rom();
		write_boot_rom(ROM_DISK);
		send_item(CMD_FETCH, 16'h3FFF, 8'h00);
		send_item(CMD_FETCH, 16'h4000, 8'h00);
		// a paging write drops disk mode even without a trap check
		send_item(CMD_PORT_WR, 16'h7FFD, 8'h10);
		send_item(CMD_FETCH, 16'h4000, 8'h00);
		write_boot_rom(ROM_UNUSED);
		send_item(CMD_MEM_RD, 16'h0000, 8'h00);
		write_boot_rom(ROM_48);
		send_item(CMD_FETCH, 16'h3D80, 8'h00);
		write_boot_rom(ROM_128);
	endtask

	// Phases of random traffic, each from a fresh boot setting. Most of it is
	// trap round trips (select 48 ROM, enter disk mode, run, leave) with
	// random filler; the rest is loose random items.
	task automatic test_random_traffic();
		logic [ROM_W-1:0]  boot_order[4];
		logic [DATA_W-1:0] data;
		int unsigned       phase_end;
		bit                paused;
		boot_order = '{ROM_DISK, ROM_UNUSED, ROM_48, ROM_128};
		for (int ph = 0; ph < 6; ph++) begin
			write_boot_rom(ph < 4 ? boot_order[ph] : 2'($urandom_range(0, 3)));
			steady    = (ph == 3);
			paused    = 1'b0;
			phase_end = items_sent + 225;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 35) begin
					data = 8'($urandom_range(0, 255));
					data[LATCH_ROM48_BIT] = 1'b1;
					data[LATCH_LOCK_BIT]  = 1'b0;
					send_item(CMD_PORT_WR, port_address(1), data);
					send_item(CMD_TRAP_CHK, {TRAP_PAGE_HIGH, 8'($urandom_range(0, 255))},
						8'($urandom_range(0, 255)));
					repeat ($urandom_range(1, 5)) send_random_item();
					send_item(CMD_TRAP_CHK, 16'($urandom_range(0, 16'hFFFF)),
						8'($urandom_range(0, 255)));
				end else begin
					send_random_item();
				end
				// mid-phase: let the block run dry before going on
				if (!paused && items_sent + 110 >= phase_end) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end
		steady = 1'b0;
	endtask

	// Result side: ready drops for random stretches, with short bursts held high.
	initial begin : result_stalls
		int unsigned hold;
		int unsigned burst;
		out_ch.ready = 1'b0;
		hold  = 0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				out_ch.ready <= 1'b1;
				if (burst != 0) begin
					burst--;
				end else begin
					hold  = pick_gap();
					burst = $urandom_range(0, 6);
				end
			end
		end
	end

	// Each taken result is matched against the oldest owed translation.
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.target_kind      = kind_t'(out_ch.target_kind);
			got.bank             = out_ch.bank;
			got.page_offset      = out_ch.page_offset;
			got.write_ignored    = out_ch.write_ignored;
			got.mapping_switched = out_ch.mapping_switched;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_SHOWN)
					$display("%0t: item with none owed: kind %0d bank %0d offset 0x%h",
						$time, got.target_kind, got.bank, got.page_offset);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= MAX_SHOWN)
						$display({"%0t: expected kind %0d bank %0d offset 0x%h ign %b sw %b,",
							" got kind %0d bank %0d offset 0x%h ign %b sw %b"}, $time,
							want.target_kind, want.bank, want.page_offset,
							want.write_ignored, want.mapping_switched,
							got.target_kind, got.bank, got.page_offset,
							got.write_ignored, got.mapping_switched);
				end
			end
		end
	end

	initial begin
		in_ch.valid     = 1'b0;
		in_ch.command   = '0;
		in_ch.address   = '0;
		in_ch.data_byte = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		arst_n          = 1'b0;
		steady          = 1'b0;
		items_sent      = 0;
		error_count     = 0;
		// reset state: boot code 0, so 128 ROM and a clear latch
		latch           = '0;
		rom_sel         = ROM_128;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_map();
		test_trap_flow();
		test_paging_port();
		test_boot_rom();
		test_random_traffic();

		drain_results();
		repeat (4) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
